@@ src/sbs_pkg.sv @@
// Shared constants, config type and overlap derivation for the stitch block.
package sbs_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int COL_W     = 12;
  localparam int OCOL_W    = 13;
  localparam int REG_W     = 13;
  localparam int PIX_W     = 8;
  localparam int NCH       = 3;
  localparam int DIV_BITS  = 8;
  localparam int NUM_W     = 20;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int REG_SEL   = 2;

  localparam logic [REG_W-1:0] WIDTH_RST = 13'd1920;
  localparam logic [REG_W-1:0] OVL_RST   = 13'd0;

  localparam logic REG_IDX_WIDTH = 1'b0;
  localparam logic REG_IDX_OVL   = 1'b1;

  typedef struct packed {
    logic [REG_W-1:0] w;
    logic [COL_W-1:0] o;
    logic [REG_W-1:0] k;
    logic [COL_W-1:0] d;
  } cfg_t;

  // Saturate width, clamp overlap to width minus two, force it even.
  function automatic cfg_t derive_cfg(logic [REG_W-1:0] iw, logic [REG_W-1:0] ovr);
    cfg_t             c;
    logic [REG_W-1:0] lim;
    logic [REG_W-1:0] o13;
    c.w = (iw > REG_W'(MAX_WIDTH)) ? REG_W'(MAX_WIDTH) : iw;
    lim = c.w - 13'd2;
    if (c.w <= 13'd2) begin
      o13 = '0;
    end else begin
      o13    = (ovr < lim) ? ovr : lim;
      o13[0] = 1'b0;
    end
    c.o = o13[COL_W-1:0];
    c.k = c.w - o13;
    c.d = (o13 > 13'd1) ? COL_W'(o13 - 13'd1) : 12'd1;
    return c;
  endfunction

endpackage

@@ src/sbs_in_if.sv @@
// Input channel: one column with its left and right camera pixels.
interface sbs_in_if;
  logic                         valid;
  logic                         ready;
  logic [sbs_pkg::COL_W-1:0]    col;
  logic [sbs_pkg::PIX_W-1:0]    left_b;
  logic [sbs_pkg::PIX_W-1:0]    left_g;
  logic [sbs_pkg::PIX_W-1:0]    left_r;
  logic [sbs_pkg::PIX_W-1:0]    right_b;
  logic [sbs_pkg::PIX_W-1:0]    right_g;
  logic [sbs_pkg::PIX_W-1:0]    right_r;

  modport source (output valid, col, left_b, left_g, left_r, right_b, right_g, right_r,
                  input ready);
  modport sink (input valid, col, left_b, left_g, left_r, right_b, right_g, right_r,
                output ready);
endinterface

@@ src/sbs_out_if.sv @@
// Result channel: one stitched pixel with its output column.
interface sbs_out_if;
  logic                         valid;
  logic                         ready;
  logic [sbs_pkg::OCOL_W-1:0]   out_col;
  logic [sbs_pkg::PIX_W-1:0]    pix_b;
  logic [sbs_pkg::PIX_W-1:0]    pix_g;
  logic [sbs_pkg::PIX_W-1:0]    pix_r;
  logic                         last;

  modport source (output valid, out_col, pix_b, pix_g, pix_r, last, input ready);
  modport sink (input valid, out_col, pix_b, pix_g, pix_r, last, output ready);
endinterface

@@ src/sbs_cfg.sv @@
// APB register file for width and overlap, with registered derived geometry.
module sbs_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sbs_pkg::APB_AW-1:0]    paddr,
  input  logic [sbs_pkg::APB_DW-1:0]    pwdata,
  output logic [sbs_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  output sbs_pkg::cfg_t                 cfg
);

  logic [sbs_pkg::REG_W-1:0] iw_r, iw_nxt;
  logic [sbs_pkg::REG_W-1:0] ovr_r, ovr_nxt;
  sbs_pkg::cfg_t             cfg_r;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    iw_nxt  = iw_r;
    ovr_nxt = ovr_r;
    if (wr_en) begin
      case (paddr[sbs_pkg::REG_SEL])
        sbs_pkg::REG_IDX_WIDTH: iw_nxt  = pwdata[sbs_pkg::REG_W-1:0];
        sbs_pkg::REG_IDX_OVL:   ovr_nxt = pwdata[sbs_pkg::REG_W-1:0];
        default:                iw_nxt  = iw_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[sbs_pkg::REG_SEL])
      sbs_pkg::REG_IDX_WIDTH: prdata = sbs_pkg::APB_DW'(iw_r);
      sbs_pkg::REG_IDX_OVL:   prdata = sbs_pkg::APB_DW'(ovr_r);
      default:                prdata = '0;
    endcase
  end

  // Derive geometry from the next values so it tracks the write edge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iw_r  <= sbs_pkg::WIDTH_RST;
      ovr_r <= sbs_pkg::OVL_RST;
      cfg_r <= sbs_pkg::derive_cfg(sbs_pkg::WIDTH_RST, sbs_pkg::OVL_RST);
    end else begin
      iw_r  <= iw_nxt;
      ovr_r <= ovr_nxt;
      cfg_r <= sbs_pkg::derive_cfg(iw_nxt, ovr_nxt);
    end
  end

  assign cfg = cfg_r;

endmodule

@@ src/side_by_side_stitch_with_overlap_blend_unit.sv @@
// Side-by-side row stitcher with a linear cross-fade over the overlap.
//
// in_if carries one column index with the left and right camera pixels at
// that column; out_if carries stitched pixels with their output column and
// a last flag on the final beat of each input item. Columns of a row must
// arrive in increasing order so that buffered right pixels of the overlap
// are in place before the matching blend reads them.
// An item gives one beat (left or blended pixel), plus a second beat with
// the right pixel when its column lies past the overlap; a column at or
// beyond the width gives none.
// An item passes the input stage, multiply stage, eight restoring-divide
// stages of one quotient bit each, then round and select, which presents
// the first beat of the item.
// Throughput: one item per cycle while the receiver is ready; a two-beat item
// holds the output stage until both beats are taken, so the output sets the rate.
// Each stage moves when it is empty or the one after it moves, so bubbles
// are squeezed out and input is still taken while a result waits.
// Reset clears all stage valids and loads width 1920, overlap 0, but not the
// overlap buffer. A receiver stall holds the output stage. Registers are to
// be written through the APB port while no item is in flight (not enforced).
module side_by_side_stitch_with_overlap_blend_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  sbs_in_if.sink                        in_if,
  sbs_out_if.source                     out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sbs_pkg::APB_AW-1:0]    paddr,
  input  logic [sbs_pkg::APB_DW-1:0]    pwdata,
  output logic [sbs_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  localparam int NSTG   = sbs_pkg::DIV_BITS + 3;
  localparam int LAST   = NSTG - 1;
  localparam int DIVEND = NSTG - 2;

  typedef struct packed {
    logic [sbs_pkg::OCOL_W-1:0]                     col1;
    logic [sbs_pkg::OCOL_W-1:0]                     col2;
    logic                                           two;
    logic                                           blend;
    logic [sbs_pkg::COL_W-1:0]                      x;
    logic [sbs_pkg::NCH-1:0][sbs_pkg::PIX_W-1:0]    lpix;
    logic [sbs_pkg::NCH-1:0][sbs_pkg::PIX_W-1:0]    rpix;
    logic [sbs_pkg::NCH-1:0][sbs_pkg::NUM_W-1:0]    rem;
    logic [sbs_pkg::NCH-1:0][sbs_pkg::PIX_W-1:0]    quo;
  } item_t;

  sbs_pkg::cfg_t cfg;

  sbs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic [sbs_pkg::NCH*sbs_pkg::PIX_W-1:0] store_mem [sbs_pkg::MAX_WIDTH];
  logic [sbs_pkg::NCH*sbs_pkg::PIX_W-1:0] rd_r;

  item_t            pipe_r  [NSTG];
  item_t            stg_nxt [NSTG];
  logic [NSTG-1:0]  vld_r;
  logic [NSTG-1:0]  vld_in;
  logic [NSTG-1:0]  rdy;
  logic             phase_r;
  logic             in_fire;
  logic             in_range;
  logic             out_fire;
  logic             last_beat;

  assign in_fire   = in_if.valid && in_if.ready;
  assign in_range  = {1'b0, in_if.col} < cfg.w;
  assign last_beat = phase_r || !pipe_r[LAST].two;
  assign out_fire  = out_if.valid && out_if.ready;
  assign in_if.ready = rdy[0];

  always_comb begin
    rdy[LAST] = !vld_r[LAST] || (out_if.ready && last_beat);
    for (int s = LAST - 1; s >= 0; s--) begin
      rdy[s] = !vld_r[s] || rdy[s+1];
    end
    vld_in[0] = in_fire && in_range;
    for (int s = 1; s < NSTG; s++) begin
      vld_in[s] = vld_r[s-1];
    end
  end

  // Stage logic: input decode, multiply, one quotient bit per stage, round and select.
  always_comb begin
    logic [sbs_pkg::NUM_W-1:0]   dsh;
    logic [sbs_pkg::COL_W-1:0]   dmx;
    logic [sbs_pkg::OCOL_W-1:0]  rem2;
    logic [sbs_pkg::OCOL_W-1:0]  dd;
    logic                        up;

    stg_nxt[0].col1  = {1'b0, in_if.col};
    stg_nxt[0].col2  = cfg.k + {1'b0, in_if.col};
    stg_nxt[0].two   = in_if.col >= cfg.o;
    stg_nxt[0].blend = {1'b0, in_if.col} >= cfg.k;
    stg_nxt[0].x     = in_if.col - cfg.k[sbs_pkg::COL_W-1:0];
    stg_nxt[0].lpix  = {in_if.left_r, in_if.left_g, in_if.left_b};
    stg_nxt[0].rpix  = {in_if.right_r, in_if.right_g, in_if.right_b};
    stg_nxt[0].rem   = '0;
    stg_nxt[0].quo   = '0;

    dmx  = cfg.d - pipe_r[0].x;
    dd   = {1'b0, cfg.d};
    dsh  = '0;
    rem2 = '0;
    up   = 1'b0;

    for (int s = 1; s < NSTG; s++) begin
      stg_nxt[s] = pipe_r[s-1];
      if (s == 1) begin
        stg_nxt[s].quo = '0;
        for (int ch = 0; ch < sbs_pkg::NCH; ch++) begin
          stg_nxt[s].rem[ch] =
            sbs_pkg::NUM_W'(pipe_r[0].lpix[ch]) * sbs_pkg::NUM_W'(dmx) +
            sbs_pkg::NUM_W'(rd_r[ch*sbs_pkg::PIX_W +: sbs_pkg::PIX_W]) *
            sbs_pkg::NUM_W'(pipe_r[0].x);
        end
      end else if (s <= DIVEND) begin
        dsh = sbs_pkg::NUM_W'(cfg.d) << (DIVEND - s);
        for (int ch = 0; ch < sbs_pkg::NCH; ch++) begin
          if (pipe_r[s-1].rem[ch] >= dsh) begin
            stg_nxt[s].rem[ch]               = pipe_r[s-1].rem[ch] - dsh;
            stg_nxt[s].quo[ch][DIVEND - s]   = 1'b1;
          end
        end
      end else begin
        // Round half to even, then pick the blend or the plain left pixel.
        for (int ch = 0; ch < sbs_pkg::NCH; ch++) begin
          rem2 = {pipe_r[s-1].rem[ch][sbs_pkg::COL_W-1:0], 1'b0};
          up   = (rem2 > dd) || ((rem2 == dd) && pipe_r[s-1].quo[ch][0]);
          stg_nxt[s].quo[ch] = pipe_r[s-1].blend ?
                               (pipe_r[s-1].quo[ch] + sbs_pkg::PIX_W'(up)) :
                               pipe_r[s-1].lpix[ch];
        end
      end
    end
  end

  // Overlap buffer: write right pixel of overlap columns, read blend partner.
  always_ff @(posedge clk) begin
    if (in_fire && in_range && !stg_nxt[0].two) begin
      store_mem[in_if.col[sbs_pkg::ADDR_W-1:0]] <= stg_nxt[0].rpix;
    end
    if (rdy[0]) begin
      rd_r <= store_mem[stg_nxt[0].x[sbs_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      phase_r <= 1'b0;
    end else begin
      for (int s = 0; s < NSTG; s++) begin
        if (rdy[s]) begin
          vld_r[s] <= vld_in[s];
        end
      end
      if (out_fire) begin
        phase_r <= !last_beat;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NSTG; s++) begin
      if (rdy[s]) begin
        pipe_r[s] <= stg_nxt[s];
      end
    end
  end

  assign out_if.valid   = vld_r[LAST];
  assign out_if.out_col = phase_r ? pipe_r[LAST].col2 : pipe_r[LAST].col1;
  assign out_if.pix_b   = phase_r ? pipe_r[LAST].rpix[0] : pipe_r[LAST].quo[0];
  assign out_if.pix_g   = phase_r ? pipe_r[LAST].rpix[1] : pipe_r[LAST].quo[1];
  assign out_if.pix_r   = phase_r ? pipe_r[LAST].rpix[2] : pipe_r[LAST].quo[2];
  assign out_if.last    = last_beat;

  a_phase_two: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> vld_r[LAST] && pipe_r[LAST].two)
    else $error("second beat pending without a two-beat item");

  a_drop_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_range |=> !vld_r[0])
    else $error("out-of-range column entered the pipeline");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[DIVEND] && pipe_r[DIVEND].blend |->
      pipe_r[DIVEND].rem[0] < sbs_pkg::NUM_W'(cfg.d) &&
      pipe_r[DIVEND].rem[1] < sbs_pkg::NUM_W'(cfg.d) &&
      pipe_r[DIVEND].rem[2] < sbs_pkg::NUM_W'(cfg.d))
    else $error("divider remainder not below divisor");

  a_second_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !last_beat |=> phase_r && vld_r[LAST])
    else $error("second beat lost after first beat");

endmodule
